[sv/dpm_pkg.sv]
// ----------------------------------------------------------------------------
// dpm_pkg: shared definitions for the dual palette merge block
// Constants, register indexes, command modes and the configuration bundle.
// ----------------------------------------------------------------------------
package dpm_pkg;

  localparam int MAX_ENTRIES_DEF  = 256;
  localparam int PALETTE_SIZE_DEF = 256;

  localparam int COLOUR_W = 24;   // packed R:G:B
  localparam int INDEX_W  = 8;    // palette index and pixel width
  localparam int PAIR_W   = 2 * INDEX_W;
  localparam int DIST_W   = 11;   // 2R+4G+B tops out at 1785
  localparam int THR_W    = 12;
  localparam int SUM_W    = 12;   // d1 + d2 and the running best

  localparam logic [SUM_W-1:0] DIFF_LIMIT = 12'd3000;
  localparam logic [THR_W-1:0] THR_RESET  = 12'd350;

  // command modes
  localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [1:0] MODE_PIXEL       = 2'd2;

  // register index (paddr bit 2)
  localparam logic REG_THR_FIRST  = 1'b0;
  localparam logic REG_THR_SECOND = 1'b1;

  typedef struct packed {
    logic [THR_W-1:0] thr_first;
    logic [THR_W-1:0] thr_second;
  } cfg_t;

endpackage

[sv/dpm_ram.sv]
// ----------------------------------------------------------------------------
// dpm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module dpm_ram #(
  parameter int WIDTH = dpm_pkg::COLOUR_W,
  parameter int DEPTH = dpm_pkg::PALETTE_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/dpm_dist.sv]
// ----------------------------------------------------------------------------
// dpm_dist: weighted colour distance unit
// Computes 2|dR| + 4|dG| + |dB| for both palettes, registered outputs.
// ----------------------------------------------------------------------------
module dpm_dist (
  input  logic                          clk,
  input  logic [dpm_pkg::COLOUR_W-1:0]  ref_a,
  input  logic [dpm_pkg::COLOUR_W-1:0]  ref_b,
  input  logic [dpm_pkg::COLOUR_W-1:0]  col_a,
  input  logic [dpm_pkg::COLOUR_W-1:0]  col_b,
  output logic [dpm_pkg::DIST_W-1:0]    dist_a,
  output logic [dpm_pkg::DIST_W-1:0]    dist_b
);

  function automatic logic [7:0] absdiff(input logic [7:0] x, input logic [7:0] y);
    absdiff = (x > y) ? (x - y) : (y - x);
  endfunction

  function automatic logic [dpm_pkg::DIST_W-1:0] weighted(
    input logic [dpm_pkg::COLOUR_W-1:0] c1,
    input logic [dpm_pkg::COLOUR_W-1:0] c2
  );
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
    dr = absdiff(c1[23:16], c2[23:16]);
    dg = absdiff(c1[15:8], c2[15:8]);
    db = absdiff(c1[7:0], c2[7:0]);
    weighted = {2'b00, dr, 1'b0} + {1'b0, dg, 2'b00} + {3'b000, db};
  endfunction

  always_ff @(posedge clk) begin
    dist_a <= weighted(ref_a, col_a);
    dist_b <= weighted(ref_b, col_b);
  end

endmodule

[sv/dpm_cfg.sv]
// ----------------------------------------------------------------------------
// dpm_cfg: APB register file
// Two 12-bit threshold registers at byte offsets 0 and 4.
// ----------------------------------------------------------------------------
module dpm_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                reg_sel,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output dpm_pkg::cfg_t       cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr_first  <= dpm_pkg::THR_RESET;
      cfg.thr_second <= dpm_pkg::THR_RESET;
    end else if (wr_en) begin
      if (reg_sel == dpm_pkg::REG_THR_FIRST) begin
        cfg.thr_first <= pwdata[dpm_pkg::THR_W-1:0];
      end else begin
        cfg.thr_second <= pwdata[dpm_pkg::THR_W-1:0];
      end
    end
  end

  assign prdata = (reg_sel == dpm_pkg::REG_THR_SECOND)
                  ? {20'd0, cfg.thr_second} : {20'd0, cfg.thr_first};

endmodule

[sv/dual_palette_merge_core.sv]
// ----------------------------------------------------------------------------
// dual_palette_merge_core: merges pixel pairs of two paletted images
// Palette loads, then per pixel pair a scan of the pair table for an exact
// match and the nearest qualifying entry (if colours differ); appends otherwise.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   -------------------------  --------------------------------------
//  command   start / busy               mode, entry_index, red, green, blue,
//                                       first_pixel, second_pixel
//  result    done (one-cycle strobe)    merged_index, added_entry, table_full,
//                                       entry_count
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  Palette loads and unused modes never raise busy. A pixel beat keeps busy
//  high through fetch, colour, scan and decide; the pair table is read one
//  entry per cycle through a four-stage pipe (pair RAM, palette RAMs,
//  distance unit, compare), and the scan ends once the pipe has drained. done
//  pulses as busy falls.
//  Reset clears the sequencer and pair count and presets the thresholds; the
//  RAMs hold whatever was last written. The result side has no back-pressure.
// ----------------------------------------------------------------------------
module dual_palette_merge_core #(
  parameter int MAX_ENTRIES  = dpm_pkg::MAX_ENTRIES_DEF,
  parameter int PALETTE_SIZE = dpm_pkg::PALETTE_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // command
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  first_pixel,
  input  logic [7:0]  second_pixel,
  // result
  output logic        done,
  output logic [7:0]  merged_index,
  output logic        added_entry,
  output logic        table_full,
  output logic [8:0]  entry_count,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = $clog2(PALETTE_SIZE);
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int CLR_W = dpm_pkg::COLOUR_W;

  localparam logic [8:0]    PAL_LIMIT = 9'(PALETTE_SIZE);
  localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_ENTRIES);

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FETCH  = 3'd1;  // read pixel colours
  localparam logic [2:0] ST_COLOUR = 3'd2;  // latch colours, arm scan
  localparam logic [2:0] ST_SCAN   = 3'd3;  // walk pair table
  localparam logic [2:0] ST_DECIDE = 3'd4;  // pick result, maybe append

  logic [2:0] state;
  logic [2:0] state_next;

  dpm_pkg::cfg_t cfg;

  // latched pixel pair
  logic [7:0]       fp_q;
  logic [7:0]       sp_q;
  logic             fp_oor;
  logic             sp_oor;
  logic [CLR_W-1:0] ca;
  logic [CLR_W-1:0] cb;

  logic [CW-1:0] pair_count;
  logic [CW-1:0] k_issue;

  // scan pipe
  logic          v_b;
  logic          v_c;
  logic          v_d;
  logic [EW-1:0] k_b;
  logic [EW-1:0] k_c;
  logic [EW-1:0] k_d;
  logic          oor_a_c;
  logic          oor_b_c;

  // search state
  logic                      found;
  logic [EW-1:0]             match_k;
  logic [dpm_pkg::SUM_W-1:0] best;
  logic                      best_hit;
  logic [EW-1:0]             best_k;

  // RAM signals
  logic                          pal_a_we;
  logic                          pal_b_we;
  logic [PW-1:0]                 pal_waddr;
  logic [CLR_W-1:0]              pal_wdata;
  logic [PW-1:0]                 pal_a_raddr;
  logic [PW-1:0]                 pal_b_raddr;
  logic [CLR_W-1:0]              pal_a_rdata;
  logic [CLR_W-1:0]              pal_b_rdata;
  logic                          pair_we;
  logic [dpm_pkg::PAIR_W-1:0]    pair_rdata;
  logic [7:0]                    pr_first;
  logic [7:0]                    pr_second;

  logic [CLR_W-1:0]           col_a;
  logic [CLR_W-1:0]           col_b;
  logic [dpm_pkg::DIST_W-1:0] dist_a;
  logic [dpm_pkg::DIST_W-1:0] dist_b;
  logic [dpm_pkg::SUM_W-1:0]  dist_sum;
  logic                       qualify;

  logic          accept;
  logic          issue;
  logic          need_append;
  logic          room;
  logic [CW-1:0] res_k;
  logic [CW+7:0] res_wide;
  logic [CW+8:0] cnt_wide;
  logic [CW-1:0] count_after;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  dpm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .reg_sel (paddr[2]),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // --------------------------------------------------------------------------
  // palettes: written by load beats, read for the pixel colours and then
  // at the indices coming out of the pair table
  // --------------------------------------------------------------------------
  assign pal_waddr = entry_index[PW-1:0];
  assign pal_wdata = {red, green, blue};
  assign pal_a_we  = accept && (mode == dpm_pkg::MODE_LOAD_FIRST)
                     && ({1'b0, entry_index} < PAL_LIMIT);
  assign pal_b_we  = accept && (mode == dpm_pkg::MODE_LOAD_SECOND)
                     && ({1'b0, entry_index} < PAL_LIMIT);

  assign pr_first  = pair_rdata[dpm_pkg::PAIR_W-1:dpm_pkg::INDEX_W];
  assign pr_second = pair_rdata[dpm_pkg::INDEX_W-1:0];

  assign pal_a_raddr = (state == ST_FETCH) ? fp_q[PW-1:0] : pr_first[PW-1:0];
  assign pal_b_raddr = (state == ST_FETCH) ? sp_q[PW-1:0] : pr_second[PW-1:0];

  dpm_ram #(.WIDTH(CLR_W), .DEPTH(PALETTE_SIZE)) u_pal_a (
    .clk   (clk),
    .we    (pal_a_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (pal_a_raddr),
    .rdata (pal_a_rdata)
  );

  dpm_ram #(.WIDTH(CLR_W), .DEPTH(PALETTE_SIZE)) u_pal_b (
    .clk   (clk),
    .we    (pal_b_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (pal_b_raddr),
    .rdata (pal_b_rdata)
  );

  // pair table: {first index, second index}, appended at pair_count
  dpm_ram #(.WIDTH(dpm_pkg::PAIR_W), .DEPTH(MAX_ENTRIES)) u_pairs (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_count[EW-1:0]),
    .wdata ({fp_q, sp_q}),
    .raddr (k_issue[EW-1:0]),
    .rdata (pair_rdata)
  );

  // --------------------------------------------------------------------------
  // distance unit, fed from stage C; out-of-range indices read as black
  // --------------------------------------------------------------------------
  assign col_a = oor_a_c ? '0 : pal_a_rdata;
  assign col_b = oor_b_c ? '0 : pal_b_rdata;

  dpm_dist u_dist (
    .clk    (clk),
    .ref_a  (ca),
    .ref_b  (cb),
    .col_a  (col_a),
    .col_b  (col_b),
    .dist_a (dist_a),
    .dist_b (dist_b)
  );

  assign dist_sum = {1'b0, dist_a} + {1'b0, dist_b};
  assign qualify  = ({1'b0, dist_a} < cfg.thr_first)
                    && ({1'b0, dist_b} < cfg.thr_second)
                    && (dist_sum < best);

  // --------------------------------------------------------------------------
  // decision
  // --------------------------------------------------------------------------
  assign issue = (state == ST_SCAN) && (k_issue < pair_count);
  assign room  = (pair_count < MAX_CNT);

  always_comb begin
    need_append = 1'b0;
    res_k       = '0;
    if (found) begin
      res_k = CW'(match_k);
    end else if ((ca != cb) && best_hit) begin
      res_k = CW'(best_k);
    end else begin
      need_append = 1'b1;
      res_k       = room ? pair_count : '0;
    end
  end

  assign pair_we     = (state == ST_DECIDE) && need_append && room;
  assign count_after = pair_we ? (pair_count + CW'(1)) : pair_count;
  assign res_wide    = {8'd0, res_k};
  assign cnt_wide    = {9'd0, count_after};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (mode == dpm_pkg::MODE_PIXEL)) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH:  state_next = ST_COLOUR;
      ST_COLOUR: state_next = ST_SCAN;
      ST_SCAN: begin
        if (!issue && !v_b && !v_c && !v_d) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pair_count <= '0;
      v_b        <= 1'b0;
      v_c        <= 1'b0;
      v_d        <= 1'b0;
      found      <= 1'b0;
      best_hit   <= 1'b0;
      done       <= 1'b0;
      k_issue    <= '0;
    end else begin
      state <= state_next;
      v_b   <= issue;
      v_c   <= v_b;
      v_d   <= v_c;
      done  <= (state == ST_DECIDE);
      if (state == ST_COLOUR) begin
        k_issue  <= '0;
        found    <= 1'b0;
        best_hit <= 1'b0;
      end else begin
        if (issue) begin
          k_issue <= k_issue + CW'(1);
        end
        // first exact match wins
        if (v_b && !found && (pr_first == fp_q) && (pr_second == sp_q)) begin
          found <= 1'b1;
        end
        if (v_d && qualify) begin
          best_hit <= 1'b1;
        end
      end
      if (pair_we) begin
        pair_count <= pair_count + CW'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      fp_q   <= first_pixel;
      sp_q   <= second_pixel;
      fp_oor <= ({1'b0, first_pixel} >= PAL_LIMIT);
      sp_oor <= ({1'b0, second_pixel} >= PAL_LIMIT);
    end
    if (state == ST_COLOUR) begin
      ca   <= fp_oor ? '0 : pal_a_rdata;
      cb   <= sp_oor ? '0 : pal_b_rdata;
      best <= dpm_pkg::DIFF_LIMIT;
    end else if (v_d && qualify) begin
      best   <= dist_sum;
      best_k <= k_d;
    end
    if (v_b && !found && (pr_first == fp_q) && (pr_second == sp_q)) begin
      match_k <= k_b;
    end
    k_b     <= k_issue[EW-1:0];
    k_c     <= k_b;
    k_d     <= k_c;
    oor_a_c <= ({1'b0, pr_first} >= PAL_LIMIT);
    oor_b_c <= ({1'b0, pr_second} >= PAL_LIMIT);
    if (state == ST_DECIDE) begin
      merged_index <= res_wide[7:0];
      added_entry  <= pair_we;
      table_full   <= need_append && !room;
      entry_count  <= cnt_wide[8:0];
    end
  end

`ifndef SYNTHESIS
  // a pixel beat always raises busy
  assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == dpm_pkg::MODE_PIXEL)) |=> busy)
    else $error("pixel beat did not start the sequencer");

  // result strobe follows the decision cycle and only then
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_DECIDE) && !busy)
    else $error("result strobe out of sequence");

  // an append and a full flag never come together
  assert property (@(posedge clk) disable iff (rst)
    done |-> !(added_entry && table_full))
    else $error("added_entry and table_full both set");

  // the pair table never grows past its depth
  assert property (@(posedge clk) disable iff (rst)
    pair_count <= MAX_CNT)
    else $error("pair count beyond table depth");
`endif

endmodule
